>>> sv/sukt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sukt_pkg
// Shared types and constants for the sorted unique key table.
// ----------------------------------------------------------------------------
package sukt_pkg;

  localparam int unsigned KEY_W  = 37;  // key width
  localparam int unsigned POS_W  = 7;   // position and entry count field width
  localparam int unsigned STAT_W = 2;
  localparam int unsigned REQ_W  = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TREE1,
    S_TREE2,
    S_COMMIT
  } state_e;

  // broadcast command to every cell of the chain
  typedef struct packed {
    logic cmp;  // latch compare flags against the incoming word
    logic ins;  // open a gap at the ordered slot and write the new entry
    logic rm;   // close the gap at the selected position
  } cell_cmd_t;

endpackage

>>> sv/sukt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sukt_cell
// One slot of the ordered chain: holds an entry, compares it against the
// broadcast key and shifts to or from its neighbours on command.
// ----------------------------------------------------------------------------
module sukt_cell import sukt_pkg::*; #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned PB   = 16,
  parameter int unsigned CMPW = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_cmd_t           cmd_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [POS_W-1:0]    pos_i,
  input  logic [CMPW-1:0]     cnt_i,
  input  logic [KEY_W-1:0]    new_key_i,
  input  logic [PB-1:0]       new_payload_i,
  input  logic [KEY_W-1:0]    left_key_i,
  input  logic [PB-1:0]       left_payload_i,
  input  logic                left_lt_i,
  input  logic [KEY_W-1:0]    right_key_i,
  input  logic [PB-1:0]       right_payload_i,
  output logic [KEY_W-1:0]    key_o,
  output logic [PB-1:0]       payload_o,
  output logic                lt_o,
  output logic [KEY_W+PB:0]   red_o
);

  // 1-based position of this slot
  localparam logic [CMPW-1:0] POS_HERE = CMPW'(IDX + 1);

  logic [KEY_W-1:0] key_q, key_d;
  logic [PB-1:0]    pay_q, pay_d;
  logic             eq_q, lt_q, sel_q, ge_q;
  logic             occ;
  logic [CMPW-1:0]  pos_ext;

  assign occ     = (POS_HERE <= cnt_i);
  assign pos_ext = CMPW'(pos_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_q  <= 1'b0;
      lt_q  <= 1'b0;
      sel_q <= 1'b0;
      ge_q  <= 1'b0;
    end else if (cmd_i.cmp) begin
      eq_q  <= occ && (key_q == key_i);
      lt_q  <= occ && (key_q < key_i);
      sel_q <= (POS_HERE == pos_ext);
      ge_q  <= (POS_HERE >= pos_ext);
    end
  end

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (cmd_i.ins && !lt_q) begin
      // first slot not below the key takes the new word, later ones shift up
      if (left_lt_i) begin
        key_d = new_key_i;
        pay_d = new_payload_i;
      end else begin
        key_d = left_key_i;
        pay_d = left_payload_i;
      end
    end else if (cmd_i.rm && ge_q) begin
      key_d = right_key_i;
      pay_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

  assign key_o     = key_q;
  assign payload_o = pay_q;
  assign lt_o      = lt_q;
  assign red_o     = {eq_q, (sel_q ? key_q : KEY_W'(0)), (sel_q ? pay_q : PB'(0))};

endmodule

>>> sv/sukt_or_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sukt_or_tree
// Two-stage registered OR reduction over the cell outputs.
// ----------------------------------------------------------------------------
module sukt_or_tree #(
  parameter int unsigned N = 64,
  parameter int unsigned W = 54
) (
  input  logic                clk_i,
  input  logic [N-1:0][W-1:0] in_i,
  output logic [W-1:0]        out_o
);

  localparam int unsigned GS = 32;
  localparam int unsigned NG = (N + GS - 1) / GS;

  logic [NG*GS-1:0][W-1:0] pad;
  logic [NG-1:0][W-1:0]    grp_d, grp_q;
  logic [W-1:0]            all_d, all_q;

  always_comb begin
    pad        = '0;
    pad[N-1:0] = in_i;
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GS; j++) begin
        grp_d[g] = grp_d[g] | pad[g*GS + j];
      end
    end
  end

  always_comb begin
    all_d = '0;
    for (int g = 0; g < NG; g++) begin
      all_d = all_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    all_q <= all_d;
  end

  assign out_o = all_q;

endmodule

>>> sv/sorted_unique_key_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_key_table_core
// Ordered table of unique keys with payload handles, built as a cell chain.
// ----------------------------------------------------------------------------
// Holds up to CAPACITY entries in ascending key order in a chain of cells.
// Each request word (insert, remove at position, read at position, clear)
// gets exactly one result word. A request passes these steps from acceptance
// to result: the per-cell compare flags are latched against the broadcast
// key, the registered OR tree gathers the duplicate flag and the selected
// entry from the cells, and the commit step decides and shifts the chain.
// The next request is taken once the current one has been written to the
// output register, so no new word is accepted while one is in flight, and a
// stalled result holds the block in its last step.
// After reset the table is empty; the entry stores need no clearing pass,
// slots at or past the entry count are simply ignored.
// ----------------------------------------------------------------------------
module sorted_unique_key_table_core import sukt_pkg::*; #(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned PAYLOAD_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request side
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  input  logic [POS_W-1:0]        position_i,
  // result side
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STAT_W-1:0]       status_o,
  output logic [KEY_W-1:0]        found_key_o,
  output logic [PAYLOAD_BITS-1:0] found_payload_o,
  output logic [POS_W-1:0]        entry_count_o
);

  localparam int unsigned PB   = PAYLOAD_BITS;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned RW   = 1 + KEY_W + PB;   // dup flag, key, payload

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  req_e                req_q;
  logic [KEY_W-1:0]    req_key_q;
  logic [PB-1:0]       req_pay_q;
  logic [POS_W-1:0]    req_pos_q;
  logic [CW-1:0]       cnt_q, cnt_d;

  logic                out_valid_q;
  status_e             out_status_q;
  logic [KEY_W-1:0]    out_key_q;
  logic [PB-1:0]       out_pay_q;
  logic [POS_W-1:0]    out_cnt_q;

  logic                in_accept;
  logic                out_free;
  logic                commit_en;
  cell_cmd_t           cmd;

  // decision in the commit step
  status_e             res_status;
  logic [KEY_W-1:0]    res_key;
  logic [PB-1:0]       res_pay;
  logic                do_ins, do_rm;

  logic [CMPW-1:0]     cnt_ext, cnt_d_ext, pos_ext;

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  logic [KEY_W-1:0]          cell_key [CAPACITY];
  logic [PB-1:0]             cell_pay [CAPACITY];
  logic [CAPACITY-1:0]       lt_vec;
  logic [CAPACITY-1:0][RW-1:0] red;
  logic [RW-1:0]             tree_out;

  assign cnt_ext = CMPW'(cnt_q);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    // neighbour taps; the chain ends feed back on themselves
    localparam int unsigned L = (i == 0) ? 0 : i - 1;
    localparam int unsigned R = (i == CAPACITY - 1) ? i : i + 1;

    logic left_lt;
    assign left_lt = (i == 0) ? 1'b1 : lt_vec[L];

    sukt_cell #(
      .IDX  (i),
      .PB   (PB),
      .CMPW (CMPW)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .cmd_i           (cmd),
      .key_i           (key_i),
      .pos_i           (position_i),
      .cnt_i           (cnt_ext),
      .new_key_i       (req_key_q),
      .new_payload_i   (req_pay_q),
      .left_key_i      (cell_key[L]),
      .left_payload_i  (cell_pay[L]),
      .left_lt_i       (left_lt),
      .right_key_i     (cell_key[R]),
      .right_payload_i (cell_pay[R]),
      .key_o           (cell_key[i]),
      .payload_o       (cell_pay[i]),
      .lt_o            (lt_vec[i]),
      .red_o           (red[i])
    );
  end

  sukt_or_tree #(
    .N (CAPACITY),
    .W (RW)
  ) u_tree (
    .clk_i (clk_i),
    .in_i  (red),
    .out_o (tree_out)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   begin if (in_accept) state_d = S_TREE1; end
      S_TREE1:  state_d = S_TREE2;
      S_TREE2:  state_d = S_COMMIT;
      S_COMMIT: begin if (out_free) state_d = S_IDLE; end
      default:  state_d = S_IDLE;
    endcase
  end

  // decision from the gathered flags
  assign pos_ext = CMPW'(req_pos_q);

  always_comb begin
    res_status = ST_OK;
    res_key    = '0;
    res_pay    = '0;
    do_ins     = 1'b0;
    do_rm      = 1'b0;
    cnt_d      = cnt_q;
    case (req_q)
      REQ_INSERT: begin
        if (tree_out[RW-1]) begin
          res_status = ST_DUP;
        end else if (cnt_q == CW'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          cnt_d  = CW'(cnt_q + 1'b1);
        end
      end
      REQ_CLEAR: begin
        cnt_d = '0;
      end
      REQ_REMOVE, REQ_READ: begin
        if (req_pos_q == '0 || pos_ext > cnt_ext) begin
          res_status = ST_BADPOS;
        end else begin
          res_key = tree_out[KEY_W+PB-1:PB];
          res_pay = tree_out[PB-1:0];
          if (req_q == REQ_REMOVE) begin
            do_rm = 1'b1;
            cnt_d = CW'(cnt_q - 1'b1);
          end
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign cnt_d_ext = CMPW'(cnt_d);

  // outputs of the sequencer
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    commit_en  = (state_q == S_COMMIT) && out_free;
    cmd.cmp    = in_accept;
    cmd.ins    = commit_en && do_ins;
    cmd.rm     = commit_en && do_rm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit_en) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request word held for the commit step
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q     <= req_e'(req_type_i);
      req_key_q <= key_i;
      req_pay_q <= payload_i;
      req_pos_q <= position_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (commit_en) begin
      out_status_q <= res_status;
      out_key_q    <= res_key;
      out_pay_q    <= res_pay;
      out_cnt_q    <= cnt_d_ext[POS_W-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign found_key_o     = out_key_q;
  assign found_payload_o = out_pay_q;
  assign entry_count_o   = out_cnt_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // entry count never runs past the chain length
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // below-key flags form a thermometer when the chain is sorted
  a_lt_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((lt_vec >> 1) & ~lt_vec) == '0)
    else $error("chain order broken");

  // a successful insert grows the table by exactly one
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_en && do_ins) |=> (cnt_q == CW'($past(cnt_q) + 1'b1)))
    else $error("insert did not grow the count");
`endif

endmodule
